/* hw/rtl/rimrs_pkg.sv */
// Shared constants and types for the range increment / range sum core.
// No dependencies; rimrs_div and the top level import it.
`timescale 1ns / 1ps

package rimrs_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int BLOCK_SIZE   = 64;
    localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;

    localparam int IDX_W  = 12;   // element index
    localparam int OFS_W  = 6;    // index within a block
    localparam int BLK_W  = 6;    // block number
    localparam int VAL_W  = 16;   // stored element value
    localparam int BSUM_W = 22;   // per-block sum
    localparam int SUM_W  = 28;   // query result
    localparam int LOAD_W = 32;   // raw load value
    localparam int CNT_W  = 13;   // element count register
    localparam int KIND_W = 2;
    localparam int STEP_W = 5;    // divider step counter, one step per dividend bit

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_COUNT   = 1'b1;

endpackage

/* hw/rtl/rimrs_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps

module rimrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rimrs_div.sv */
// Bit-serial restoring remainder unit: 32-bit dividend, 16-bit divisor.
// Depends on rimrs_pkg.
`timescale 1ns / 1ps

module rimrs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rimrs_pkg::LOAD_W-1:0] dividend,
    input  logic [rimrs_pkg::VAL_W-1:0]  divisor,
    output logic                        done,
    output logic [rimrs_pkg::VAL_W-1:0]  remainder
);
    import rimrs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LOAD_W-1:0] dvd_reg;
    logic [VAL_W-1:0]  dsr_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W:0]    trial;
    logic [VAL_W-1:0]  rem_step;

    // shift in one dividend bit, subtract when the divisor fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[LOAD_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_step = VAL_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_step = trial[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[LOAD_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/range_increment_mod_range_sum_core.sv */
// Top level of the range increment / range sum core.
// Depends on rimrs_pkg, rimrs_ram and rimrs_div.
`timescale 1ns / 1ps

// An array of 4096 values, each kept reduced modulo the modulus register,
// lives in an element RAM with a registered read port; a second RAM keeps the
// sum of every 64-element block, so a query over whole blocks reads one block
// sum per block. An increment reads, bumps and writes back every element of
// its clipped range at one element per cycle, plus, for each block, the
// block-sum read, the tail of the read pipeline and the block-sum update. A
// partial block of a query is read the same way. A load waits for the
// bit-serial remainder unit that reduces the 32-bit word. Items are handled
// one at a time; a finished sum waits in the output register while the next
// word is taken. Writing the modulus while idle starts a pass over all 4096
// elements (each read and checked, one that needs reducing sent through the
// remainder unit) that rebuilds the block sums; the item port is held off
// until it ends. After reset a clearing pass writes zero to all 4096 elements,
// one per cycle, and the item port stays low until it ends; a modulus written
// meanwhile only updates the register, since every element ends up zero.

module range_increment_mod_range_sum_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [rimrs_pkg::KIND_W-1:0]    kind,
    input  logic [rimrs_pkg::IDX_W-1:0]     range_first,
    input  logic [rimrs_pkg::IDX_W-1:0]     range_last,
    input  logic [rimrs_pkg::LOAD_W-1:0]    load_value,
    output logic                            sum_valid,
    input  logic                            sum_ready,
    output logic [rimrs_pkg::SUM_W-1:0]     range_sum,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [rimrs_pkg::VAL_W-1:0]     cfg_wdata
);
    import rimrs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LOAD = 10'b0000000010,
        S_BLK  = 10'b0000000100,
        S_WALK = 10'b0000001000,
        S_BFIN = 10'b0000010000,
        S_EMIT = 10'b0000100000,
        S_MRD  = 10'b0001000000,
        S_MCHK = 10'b0010000000,
        S_MDIV = 10'b0100000000,
        S_CLR  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [VAL_W-1:0] mod_reg, mod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] kk;
    logic [IDX_W-1:0] n_last;

    // operation context
    logic             inc_reg, inc_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [BLK_W-1:0] blk_last_reg, blk_last_next;
    logic             full_reg, full_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             iss_reg, iss_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [BSUM_W-1:0] delta_reg, delta_next;
    logic [BSUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] res_reg, res_next;

    // output register
    logic             sv_reg, sv_next;
    logic [SUM_W-1:0] rs_reg, rs_next;

    // block-sum valid bits
    logic [NUM_BLOCKS-1:0] bvld_reg, bvld_next;
    logic                  bvld_rd_reg;

    // memory ports
    logic              e_we, e_re;
    logic [IDX_W-1:0]  e_waddr, e_raddr;
    logic [VAL_W-1:0]  e_wdata, e_rdata;
    logic              b_we, b_re;
    logic [BLK_W-1:0]  b_waddr, b_raddr;
    logic [BSUM_W-1:0] b_wdata, b_rdata, b_eff;

    // remainder unit
    logic              d_start, d_done;
    logic [LOAD_W-1:0] d_dvd;
    logic [VAL_W-1:0]  d_rem;

    // per-block and per-element helpers
    logic [IDX_W-1:0]  blk_lo, blk_hi;
    logic [VAL_W-1:0]  bumped;
    logic [VAL_W:0]    bump_wide;
    logic              accept;
    logic              fin_en;
    logic [VAL_W-1:0]  fin_val;
    logic [BSUM_W-1:0] fin_acc;
    logic [IDX_W-1:0]  last_clip;

    rimrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    rimrs_ram #(.WIDTH(BSUM_W), .DEPTH(NUM_BLOCKS)) u_bsum (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    rimrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (d_start),
        .dividend  (d_dvd),
        .divisor   (kk),
        .done      (d_done),
        .remainder (d_rem)
    );

    // effective modulus and last index in use
    always_comb
    begin
        kk = (mod_reg == '0) ? VAL_W'(1) : mod_reg;
        if (cnt_reg == '0)
        begin
            n_last = '0;
        end
        else if (cnt_reg >= CNT_W'(MAX_ELEMENTS))
        begin
            n_last = '1;
        end
        else
        begin
            n_last = IDX_W'(cnt_reg - CNT_W'(1));
        end
    end

    assign item_ready = (state_reg == S_IDLE) && !(cfg_we && cfg_index == CFG_MODULUS);
    assign accept     = item_valid && item_ready;
    assign last_clip  = (range_last > n_last) ? n_last : range_last;

    assign blk_lo    = {blk_reg, OFS_W'(0)};
    assign blk_hi    = {blk_reg, {OFS_W{1'b1}}};
    assign b_eff     = bvld_rd_reg ? b_rdata : '0;
    assign bump_wide = {1'b0, e_rdata} + (VAL_W+1)'(1);
    assign bumped    = (bump_wide == {1'b0, kk}) ? '0 : bump_wide[VAL_W-1:0];

    // result of one element in the modulus pass
    always_comb
    begin
        fin_en  = 1'b0;
        fin_val = e_rdata;
        if (state_reg == S_MCHK && e_rdata < kk)
        begin
            fin_en = 1'b1;
        end
        else if (state_reg == S_MDIV && d_done)
        begin
            fin_en  = 1'b1;
            fin_val = d_rem;
        end
        fin_acc = acc_reg + BSUM_W'(fin_val);
    end

    always_comb
    begin
        state_next    = state_reg;
        mod_next      = mod_reg;
        cnt_next      = cnt_reg;
        inc_next      = inc_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        blk_next      = blk_reg;
        blk_last_next = blk_last_reg;
        full_next     = full_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        iss_next      = iss_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        delta_next    = delta_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        sv_next       = sv_reg && !sum_ready;
        rs_next       = rs_reg;
        bvld_next     = bvld_reg;

        e_we    = 1'b0;
        e_waddr = pidx_reg;
        e_wdata = bumped;
        e_re    = 1'b0;
        e_raddr = idx_reg;
        b_we    = 1'b0;
        b_waddr = blk_reg;
        b_wdata = b_eff + delta_reg;
        b_re    = 1'b0;
        b_raddr = blk_reg;
        d_start = 1'b0;
        d_dvd   = load_value;

        if (cfg_we && cfg_index == CFG_COUNT)
        begin
            cnt_next = cfg_wdata[CNT_W-1:0];
        end

        unique case (state_reg)
            S_CLR:
            begin
                // after reset, zero every element in index order
                e_we    = 1'b1;
                e_waddr = idx_reg;
                e_wdata = '0;
                if (cfg_we && cfg_index == CFG_MODULUS)
                begin
                    mod_next = cfg_wdata;
                end
                if (idx_reg == '1)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (cfg_we && cfg_index == CFG_MODULUS)
                begin
                    // new modulus: reduce every element and rebuild block sums
                    mod_next   = cfg_wdata;
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_MRD;
                end
                else if (accept)
                begin
                    inc_next   = (kind == KIND_INC);
                    first_next = range_first;
                    last_next  = last_clip;
                    res_next   = '0;
                    if (kind == KIND_LOAD)
                    begin
                        if (range_first <= n_last)
                        begin
                            e_re       = 1'b1;
                            e_raddr    = range_first;
                            b_re       = 1'b1;
                            b_raddr    = range_first[IDX_W-1 -: BLK_W];
                            d_start    = 1'b1;
                            state_next = S_LOAD;
                        end
                    end
                    else if (kind == KIND_INC || kind == KIND_QUERY)
                    begin
                        blk_next      = range_first[IDX_W-1 -: BLK_W];
                        blk_last_next = last_clip[IDX_W-1 -: BLK_W];
                        if (range_first <= range_last && range_first <= n_last)
                        begin
                            state_next = S_BLK;
                        end
                        else if (kind == KIND_QUERY)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end

            S_LOAD:
            begin
                // old element and block sum are held in the read registers
                if (d_done)
                begin
                    e_we      = 1'b1;
                    e_waddr   = first_reg;
                    e_wdata   = d_rem;
                    b_we      = 1'b1;
                    b_waddr   = first_reg[IDX_W-1 -: BLK_W];
                    b_wdata   = b_eff - BSUM_W'(e_rdata) + BSUM_W'(d_rem);
                    bvld_next[first_reg[IDX_W-1 -: BLK_W]] = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_BLK:
            begin
                b_re       = 1'b1;
                full_next  = (first_reg <= blk_lo) && (blk_hi <= last_reg);
                idx_next   = (first_reg > blk_lo) ? first_reg : blk_lo;
                end_next   = (last_reg < blk_hi) ? last_reg : blk_hi;
                iss_next   = 1'b1;
                delta_next = '0;
                if ((first_reg <= blk_lo) && (blk_hi <= last_reg) && !inc_reg)
                begin
                    state_next = S_BFIN;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // issue one read a cycle; retire the word read last cycle
                if (iss_reg)
                begin
                    e_re      = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = idx_reg;
                    if (idx_reg == end_reg)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                if (pv_reg)
                begin
                    if (inc_reg)
                    begin
                        e_we       = 1'b1;
                        delta_next = delta_reg + BSUM_W'(bumped) - BSUM_W'(e_rdata);
                    end
                    else
                    begin
                        res_next = res_reg + SUM_W'(e_rdata);
                    end
                end
                if (!iss_reg)
                begin
                    state_next = S_BFIN;
                end
            end

            S_BFIN:
            begin
                if (inc_reg)
                begin
                    b_we               = 1'b1;
                    bvld_next[blk_reg] = 1'b1;
                end
                else if (full_reg)
                begin
                    res_next = res_reg + SUM_W'(b_eff);
                end
                if (blk_reg == blk_last_reg)
                begin
                    state_next = inc_reg ? S_IDLE : S_EMIT;
                end
                else
                begin
                    blk_next   = blk_reg + BLK_W'(1);
                    state_next = S_BLK;
                end
            end

            S_EMIT:
            begin
                if (!sv_reg || sum_ready)
                begin
                    sv_next    = 1'b1;
                    rs_next    = res_reg;
                    state_next = S_IDLE;
                end
            end

            S_MRD:
            begin
                e_re       = 1'b1;
                state_next = S_MCHK;
            end

            S_MCHK:
            begin
                if (!(e_rdata < kk))
                begin
                    d_start    = 1'b1;
                    d_dvd      = LOAD_W'(e_rdata);
                    state_next = S_MDIV;
                end
            end

            S_MDIV:
            begin
                // wait for the remainder unit
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_en)
        begin
            e_we    = 1'b1;
            e_waddr = idx_reg;
            e_wdata = fin_val;
            acc_next = fin_acc;
            if (idx_reg[OFS_W-1:0] == '1)
            begin
                b_we      = 1'b1;
                b_waddr   = idx_reg[IDX_W-1 -: BLK_W];
                b_wdata   = fin_acc;
                bvld_next[idx_reg[IDX_W-1 -: BLK_W]] = 1'b1;
                acc_next  = '0;
            end
            if (idx_reg == '1)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_MRD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            mod_reg   <= VAL_W'(2);
            cnt_reg   <= CNT_W'(MAX_ELEMENTS);
            idx_reg   <= '0;
            iss_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            sv_reg    <= 1'b0;
            bvld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mod_reg   <= mod_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            iss_reg   <= iss_next;
            pv_reg    <= pv_next;
            sv_reg    <= sv_next;
            bvld_reg  <= bvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg      <= inc_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        blk_reg      <= blk_next;
        blk_last_reg <= blk_last_next;
        full_reg     <= full_next;
        end_reg      <= end_next;
        pidx_reg     <= pidx_next;
        delta_reg    <= delta_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        rs_reg       <= rs_next;
        if (b_re)
        begin
            bvld_rd_reg <= bvld_reg[b_raddr];
        end
    end

    assign sum_valid = sv_reg;
    assign range_sum = rs_reg;

endmodule
